>>> rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, codes and defaults for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  // default sizing
  localparam int DEQ_DEPTH      = 64;
  localparam int DEQ_DATA_WIDTH = 32;

  // fixed field widths of the request and result words
  localparam int OP_W   = 3;
  localparam int EDAT_W = 32;
  localparam int POS_W  = 6;
  localparam int RDAT_W = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 7;

  // request codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ       = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [EDAT_W-1:0] entry_data;
    logic [POS_W-1:0]  position;
  } in_word_t;

  typedef struct packed {
    logic [RDAT_W-1:0] read_data;
    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occupancy;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic exec;
    logic load_out;
  } deq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } deq_stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WB
  } state_t;

endpackage

>>> rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: accept a word, execute it, write the result back.
// ----------------------------------------------------------------------------
module deq_ctrl
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  deq_stat_t stat,
  output deq_cmd_t  cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        // wait for the output register to free up
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/deq_datapath.sv
// ----------------------------------------------------------------------------
// deq_datapath
// Ring pointers, entry memory, result and output registers.
// ----------------------------------------------------------------------------
module deq_datapath
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEQ_DEPTH,
  parameter int DATA_WIDTH = DEQ_DATA_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  output out_word_t out_word,
  output logic      out_valid,
  input  logic      out_ready,
  input  deq_cmd_t  cmd,
  output deq_stat_t stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = PW + 1;
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  // slot reached 'off' places after 'base'; 'base' below DEPTH, 'off' at most DEPTH
  function automatic logic [PW-1:0] slot_after(input logic [PW-1:0] base,
                                               input logic [SW-1:0] off);
    logic [SW-1:0] sum;
    sum = {1'b0, base} + off;
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  in_word_t        req_r;
  logic [PW-1:0]   front_r, front_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [OCC_W-1:0]  occ_r;
  logic            rd_ok_r, rd_ok_nxt;
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;
  logic            wr_en;
  logic [PW-1:0]   wr_addr;
  logic [PW-1:0]   front_dec;
  logic [PW-1:0]   slot_back;
  logic [PW-1:0]   slot_pos;
  logic [XW-1:0]   pos_x;
  logic            full, empty;
  out_word_t       out_word_r;
  logic            out_valid_r;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_word;
    end
  end

  // ring arithmetic
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign front_dec = (front_r == '0) ? PW'(DEPTH - 1) : front_r - PW'(1);
  assign slot_back = slot_after(front_r, SW'(count_r));
  assign pos_x     = XW'(req_r.position);
  assign slot_pos  = slot_after(front_r, SW'(pos_x));

  // request execution
  always_comb begin
    front_nxt  = front_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    rd_ok_nxt  = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = slot_back;
    case (req_r.op)
      OP_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          front_nxt = front_dec;
          wr_en     = 1'b1;
          wr_addr   = front_dec;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          front_nxt = slot_after(front_r, SW'(1));
          count_nxt = count_r - CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      OP_READ: begin
        if (pos_x >= XW'(count_r)) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_ok_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // queue state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  // result of the executed word
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
      occ_r    <= OCC_W'(count_nxt);
      rd_ok_r  <= rd_ok_nxt;
    end
  end

  // entry memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= DATA_WIDTH'(req_r.entry_data);
    end
    if (cmd.exec && rd_ok_nxt) begin
      rdata_r <= mem[slot_pos];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word_r.read_data <= rd_ok_r ? RDAT_W'(rdata_r) : '0;
      out_word_r.status    <= status_r;
      out_word_r.occupancy <= occ_r;
    end
  end

  assign out_word      = out_word_r;
  assign out_valid     = out_valid_r;
  assign stat.out_busy = out_valid_r && !out_ready;

endmodule

>>> rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue on a ring buffer, one result word per request.
// ----------------------------------------------------------------------------
// Each request word passes through the states S_IDLE, which accepts it,
// S_EXEC, which executes it (pointer and count update, entry memory write,
// or read address issue), and S_WB, which loads the result into the output
// register. A new request is accepted while the previous result still
// waits in the output register; write-back stalls only while that register
// is still occupied. No clearing pass runs after reset: only entries written
// by a push can ever be read.
module double_ended_queue_top
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEQ_DEPTH,
  parameter int DATA_WIDTH = DEQ_DATA_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  deq_cmd_t  cmd;
  deq_stat_t stat;

  // sequencer
  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  deq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .out_word  (out_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // one word in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while one is in flight");

  // a result never overwrites one that is not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid && !out_ready))
    else $error("result register overwritten");

  // execute always follows an accept
  a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_req |=> cmd.exec)
    else $error("execute step missed");

  // commands are exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_req, cmd.exec, cmd.load_out}))
    else $error("overlapping commands");

endmodule
